FILE: sv/scc_pkg.sv
// Shared types, constants and month table for the seconds/calendar converter.
// No dependencies; imported by scc_split, scc_build and the top level.
`default_nettype none

package scc_pkg;

  // Pipeline depth: registered stages between the input and output ports
  localparam int NSTG = 6;

  // Per-stage load enables, driven by the top-level flow control
  typedef logic [NSTG-1:0] stage_en_t;

  // Mode codes
  localparam logic MODE_SPLIT = 1'b0;  // count -> calendar
  localparam logic MODE_BUILD = 1'b1;  // calendar -> count

  // Reciprocals for constant division (floor form corrected by one compare,
  // or exact ceiling form where noted)
  localparam logic [24:0] DAY_RECIP  = 25'd25451658;  // 2^34 / 675, floor
  localparam int          DAY_SHIFT  = 34;
  localparam logic [15:0] HOUR_RECIP = 16'd37283;     // 2^27 / 3600, ceiling, exact
  localparam logic [15:0] CYC_RECIP  = 16'd45933;     // 2^26 / 1461, floor
  localparam logic [16:0] WDAY_RECIP = 17'd74898;     // 2^19 / 7, floor
  localparam logic [12:0] MIN_RECIP  = 13'd4370;      // 2^18 / 60, ceiling, exact

  // Days before the start of month idx+1 (idx 0..12)
  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = leap ? 9'd60  : 9'd59;
      4'd3:    v = leap ? 9'd91  : 9'd90;
      4'd4:    v = leap ? 9'd121 : 9'd120;
      4'd5:    v = leap ? 9'd152 : 9'd151;
      4'd6:    v = leap ? 9'd182 : 9'd181;
      4'd7:    v = leap ? 9'd213 : 9'd212;
      4'd8:    v = leap ? 9'd244 : 9'd243;
      4'd9:    v = leap ? 9'd274 : 9'd273;
      4'd10:   v = leap ? 9'd305 : 9'd304;
      4'd11:   v = leap ? 9'd335 : 9'd334;
      4'd12:   v = leap ? 9'd366 : 9'd365;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/scc_split.sv
// Six-stage datapath splitting a seconds count into calendar fields.
// Depends on scc_pkg; stage loads are driven by the top level.
`default_nettype none

module scc_split #(
  parameter int EPOCH_YEAR = 2017
) (
  input  wire logic              clk,
  input  wire scc_pkg::stage_en_t stage_en,
  input  wire logic [31:0]       count_seconds,
  output logic [5:0]             second_r,
  output logic [5:0]             minute_r,
  output logic [4:0]             hour_r,
  output logic [2:0]             weekday_r,
  output logic [4:0]             day_r,
  output logic [3:0]             month_r,
  output logic [11:0]            year_r
);
  import scc_pkg::*;

  // Leap cycles are counted from the leap year at or before the epoch
  localparam int LEAP_PHASE = EPOCH_YEAR % 4;
  localparam int LEAP_BASE  = EPOCH_YEAR - LEAP_PHASE;
  localparam int CYC_OFF    = 365 * LEAP_PHASE + ((LEAP_PHASE != 0) ? 1 : 0);

  // S1
  logic [15:0] q0_r1;
  logic [24:0] x_r1;
  logic [6:0]  lo_r1;
  logic [49:0] day_prod;
  // S2
  logic [15:0] days_r2;
  logic [16:0] secs_r2;
  logic [25:0] day_rem;
  logic        day_ge;
  logic [15:0] days_nxt;
  logic [16:0] secs_nxt;
  // S3
  logic [16:0] secs_r3;
  logic [15:0] days_r3;
  logic [16:0] dsh_r3;
  logic [4:0]  hour_r3;
  logic [5:0]  cyc0_r3;
  logic [12:0] wq0_r3;
  logic [16:0] dsh;
  logic [31:0] hour_prod;
  logic [31:0] cyc_prod;
  logic [31:0] wday_prod;
  // S4
  logic [4:0]  hour_r4;
  logic [11:0] rem_r4;
  logic [5:0]  cyc_r4;
  logic [10:0] rc_r4;
  logic [2:0]  wd_r4;
  logic [16:0] cyc_rem;
  logic        cyc_ge;
  logic [15:0] wd_rem;
  logic        wd_ge;
  logic [11:0] rem_nxt;
  logic [5:0]  cyc_nxt;
  logic [10:0] rc_nxt;
  logic [2:0]  wd_nxt;
  // S5
  logic [4:0]  hour_r5;
  logic [2:0]  wd_r5;
  logic [11:0] rem_r5;
  logic [5:0]  minute_r5;
  logic [8:0]  yday_r5;
  logic        leap_r5;
  logic [11:0] year_r5;
  logic [24:0] min_prod;
  logic [1:0]  yic;
  logic [10:0] ystart;
  logic [8:0]  yday_nxt;
  logic [11:0] year_nxt;
  // S6
  logic [3:0]  month_nxt;
  logic [4:0]  day_nxt;
  logic [5:0]  second_nxt;

  // S1: days = count / 86400 = (count >> 7) / 675, estimate by reciprocal
  assign day_prod = 50'(count_seconds[31:7]) * 50'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      q0_r1 <= day_prod[DAY_SHIFT +: 16];
      x_r1  <= count_seconds[31:7];
      lo_r1 <= count_seconds[6:0];
    end
  end

  // S2: correct the estimate, seconds of day from the remainder
  always_comb begin
    day_rem  = 26'(x_r1) - 26'(q0_r1) * 26'd675;
    day_ge   = day_rem >= 26'd675;
    days_nxt = q0_r1 + 16'(day_ge);
    secs_nxt = day_ge ? {10'(day_rem - 26'd675), lo_r1} : {day_rem[9:0], lo_r1};
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      days_r2 <= days_nxt;
      secs_r2 <= secs_nxt;
    end
  end

  // S3: hour, leap cycle estimate and week estimate
  always_comb begin
    dsh       = 17'(days_r2) + 17'(CYC_OFF);
    hour_prod = 32'(secs_r2) * 32'(HOUR_RECIP);
    cyc_prod  = 32'(dsh) * 32'(CYC_RECIP);
    wday_prod = 32'(days_r2) * 32'(WDAY_RECIP);
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      secs_r3 <= secs_r2;
      days_r3 <= days_r2;
      dsh_r3  <= dsh;
      hour_r3 <= hour_prod[31:27];
      cyc0_r3 <= cyc_prod[31:26];
      wq0_r3  <= wday_prod[31:19];
    end
  end

  // S4: remainders, with one-step corrections for the leap cycle and the weekday
  always_comb begin
    rem_nxt = 12'(secs_r3 - 17'(hour_r3) * 17'd3600);
    cyc_rem = dsh_r3 - 17'(cyc0_r3) * 17'd1461;
    cyc_ge  = cyc_rem >= 17'd1461;
    cyc_nxt = cyc0_r3 + 6'(cyc_ge);
    rc_nxt  = cyc_ge ? 11'(cyc_rem - 17'd1461) : cyc_rem[10:0];
    wd_rem  = days_r3 - 16'(wq0_r3) * 16'd7;
    wd_ge   = wd_rem >= 16'd7;
    wd_nxt  = wd_ge ? 3'(wd_rem - 16'd7) : wd_rem[2:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      hour_r4 <= hour_r3;
      rem_r4  <= rem_nxt;
      cyc_r4  <= cyc_nxt;
      rc_r4   <= rc_nxt;
      wd_r4   <= wd_nxt;
    end
  end

  // S5: minute estimate, year within the leap cycle
  always_comb begin
    min_prod = 25'(rem_r4) * 25'(MIN_RECIP);
    if (rc_r4 >= 11'd1096) begin
      yic    = 2'd3;
      ystart = 11'd1096;
    end else if (rc_r4 >= 11'd731) begin
      yic    = 2'd2;
      ystart = 11'd731;
    end else if (rc_r4 >= 11'd366) begin
      yic    = 2'd1;
      ystart = 11'd366;
    end else begin
      yic    = 2'd0;
      ystart = 11'd0;
    end
    yday_nxt = 9'(rc_r4 - ystart);
    year_nxt = 12'(LEAP_BASE) + 12'({cyc_r4, yic});
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      hour_r5   <= hour_r4;
      wd_r5     <= wd_r4;
      rem_r5    <= rem_r4;
      minute_r5 <= min_prod[23:18];
      yday_r5   <= yday_nxt;
      leap_r5   <= (yic == 2'd0);
      year_r5   <= year_nxt;
    end
  end

  // S6: month by threshold compares, day of month, second
  always_comb begin
    month_nxt = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (yday_r5 >= days_before(leap_r5, 4'(i))) month_nxt = 4'(i + 1);
    end
    day_nxt    = 5'(yday_r5 - days_before(leap_r5, month_nxt - 4'd1) + 9'd1);
    second_nxt = 6'(rem_r5 - 12'(minute_r5) * 12'd60);
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      second_r  <= second_nxt;
      minute_r  <= minute_r5;
      hour_r    <= hour_r5;
      weekday_r <= wd_r5;
      day_r     <= day_nxt;
      month_r   <= month_nxt;
      year_r    <= year_r5;
    end
  end

endmodule

`default_nettype wire

FILE: sv/scc_build.sv
// Six-stage datapath building a seconds count from calendar fields.
// Depends on scc_pkg; stage loads are driven by the top level.
`default_nettype none

module scc_build #(
  parameter int EPOCH_YEAR = 2017
) (
  input  wire logic              clk,
  input  wire scc_pkg::stage_en_t stage_en,
  input  wire logic [5:0]        second,
  input  wire logic [5:0]        minute,
  input  wire logic [4:0]        hour,
  input  wire logic [4:0]        day,
  input  wire logic [3:0]        month,
  input  wire logic [11:0]       year,
  output logic [31:0]            count_r,
  output logic                   range_error_r
);
  import scc_pkg::*;

  localparam logic [11:0] EPOCH_Y  = 12'(EPOCH_YEAR);
  localparam logic [9:0]  EPOCH_LD = 10'((EPOCH_YEAR - 1) / 4);

  // S1
  logic        bad_r1;
  logic [11:0] yoff_r1;
  logic [9:0]  leapd_r1;
  logic [8:0]  tb0_r1;
  logic [4:0]  dm1_r1;
  logic [5:0]  sec_r1;
  logic [5:0]  min_r1;
  logic [4:0]  hour_r1;
  logic        leap;
  logic [8:0]  tb0;
  logic [8:0]  tb1;
  logic        bad_nxt;
  logic [11:0] ym1;
  // S2
  logic        bad_r2;
  logic [20:0] days_r2;
  logic [16:0] tod_r2;
  // S3
  logic        bad_r3;
  logic [37:0] total_r3;
  // S4..S6
  logic        err_r4;
  logic [31:0] cnt_r4;
  logic        err_r5;
  logic [31:0] cnt_r5;
  logic        ovf;

  // S1: field checks and table lookups
  always_comb begin
    leap    = (year[1:0] == 2'd0);
    tb0     = days_before(leap, month - 4'd1);
    tb1     = days_before(leap, month);
    ym1     = year - 12'd1;
    bad_nxt = (second > 6'd59) || (minute > 6'd59) || (hour > 5'd23) ||
              (month == 4'd0) || (month > 4'd12) || (day == 5'd0) ||
              (year < EPOCH_Y) || (9'(day) > (tb1 - tb0));
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      bad_r1   <= bad_nxt;
      yoff_r1  <= year - EPOCH_Y;
      leapd_r1 <= ym1[11:2] - EPOCH_LD;
      tb0_r1   <= tb0;
      dm1_r1   <= day - 5'd1;
      sec_r1   <= second;
      min_r1   <= minute;
      hour_r1  <= hour;
    end
  end

  // S2: day number and second of day
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      bad_r2  <= bad_r1;
      days_r2 <= 21'(yoff_r1) * 21'd365 + 21'(leapd_r1) + 21'(tb0_r1) + 21'(dm1_r1);
      tod_r2  <= 17'(hour_r1) * 17'd3600 + 17'(min_r1) * 17'd60 + 17'(sec_r1);
    end
  end

  // S3: full count, 38 bits wide so overflow stays visible
  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      bad_r3   <= bad_r2;
      total_r3 <= 38'(days_r2) * 38'd86400 + 38'(tod_r2);
    end
  end

  // S4: saturate / flag
  assign ovf = |total_r3[37:32];

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      err_r4 <= bad_r3 | ovf;
      if (bad_r3) begin
        cnt_r4 <= '0;
      end else if (ovf) begin
        cnt_r4 <= '1;
      end else begin
        cnt_r4 <= total_r3[31:0];
      end
    end
  end

  // S5, S6: align with the split path
  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      err_r5 <= err_r4;
      cnt_r5 <= cnt_r4;
    end
    if (stage_en[5]) begin
      range_error_r <= err_r5;
      count_r       <= cnt_r5;
    end
  end

endmodule

`default_nettype wire

FILE: sv/seconds_calendar_converter.sv
// Seconds count <-> calendar converter: flow control, mode tracking, output select.
// Depends on scc_pkg, scc_split and scc_build.
//
// Usage:
//   Input channel (in_*): in_valid / in_stall. One transaction per item; in_mode
//   selects count-to-calendar (0, uses in_count_seconds) or calendar-to-count
//   (1, uses in_second .. in_year). Output channel (out_*): out_valid / out_stall,
//   exactly one result transaction for every input transaction, in order.
//   Fields not produced by the selected mode read as zero.
//   An accepted transaction passes through six register stages, each a short
//   step of constant multiplies, compares and adds, which carry a valid bit with
//   the data; out_valid is the valid bit of the last stage.
//   Throughput: one transaction per cycle while out_stall is low.
//   Stall: each stage loads when it is empty or the stage after it moves, so
//   bubbles close up and in_stall rises only once every stage holds an item
//   and out_stall is high. A stalled output holds its value.
//   Reset: rst_n (synchronous, active low) empties the pipeline; nothing is
//   emitted until new transactions arrive.
//   EPOCH_YEAR: year whose 1 January 00:00:00 is count zero; leap years are
//   the years divisible by four.
`default_nettype none

module seconds_calendar_converter #(
  parameter int EPOCH_YEAR = 2017
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_count_seconds,
  input  wire logic [5:0]  in_second,
  input  wire logic [5:0]  in_minute,
  input  wire logic [4:0]  in_hour,
  input  wire logic [4:0]  in_day,
  input  wire logic [3:0]  in_month,
  input  wire logic [11:0] in_year,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_second,
  output logic [5:0]       out_minute,
  output logic [4:0]       out_hour,
  output logic [2:0]       out_weekday,
  output logic [4:0]       out_day,
  output logic [3:0]       out_month,
  output logic [11:0]      out_year,
  output logic [31:0]      out_count,
  output logic             out_range_error
);
  import scc_pkg::*;

  stage_en_t       adv;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] mode_r;

  logic [5:0]  sp_second;
  logic [5:0]  sp_minute;
  logic [4:0]  sp_hour;
  logic [2:0]  sp_weekday;
  logic [4:0]  sp_day;
  logic [3:0]  sp_month;
  logic [11:0] sp_year;
  logic [31:0] bd_count;
  logic        bd_error;
  logic        last_split;

  // Stage k may load when empty or when stage k+1 loads; last stage
  // advances when the output is empty or being taken.
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign vld_nxt = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // Mode travels with each transaction
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) mode_r[k] <= (k == 0) ? in_mode : mode_r[(k == 0) ? 0 : k - 1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NSTG-1];

  scc_split #(
    .EPOCH_YEAR(EPOCH_YEAR)
  ) u_split (
    .clk          (clk),
    .stage_en     (adv),
    .count_seconds(in_count_seconds),
    .second_r     (sp_second),
    .minute_r     (sp_minute),
    .hour_r       (sp_hour),
    .weekday_r    (sp_weekday),
    .day_r        (sp_day),
    .month_r      (sp_month),
    .year_r       (sp_year)
  );

  scc_build #(
    .EPOCH_YEAR(EPOCH_YEAR)
  ) u_build (
    .clk          (clk),
    .stage_en     (adv),
    .second       (in_second),
    .minute       (in_minute),
    .hour         (in_hour),
    .day          (in_day),
    .month        (in_month),
    .year         (in_year),
    .count_r      (bd_count),
    .range_error_r(bd_error)
  );

  // Both paths run on every item; the mode picks which fields are live.
  assign last_split = (mode_r[NSTG-1] == MODE_SPLIT);

  assign out_second      = last_split ? sp_second  : '0;
  assign out_minute      = last_split ? sp_minute  : '0;
  assign out_hour        = last_split ? sp_hour    : '0;
  assign out_weekday     = last_split ? sp_weekday : '0;
  assign out_day         = last_split ? sp_day     : '0;
  assign out_month       = last_split ? sp_month   : '0;
  assign out_year        = last_split ? sp_year    : '0;
  assign out_count       = last_split ? '0 : bd_count;
  assign out_range_error = last_split ? 1'b0 : bd_error;

endmodule

`default_nettype wire

FILE: bench/seconds_calendar_converter_tb.sv
// Self-checking bench for seconds_calendar_converter: directed and random conversions
// in both modes, random idling on both channels. Depends on scc_pkg and the converter RTL.
`default_nettype none

module seconds_calendar_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scc_pkg::*;

  localparam int EPOCH_YEAR   = 2017;
  localparam int LAST_YEAR    = EPOCH_YEAR + 136;  // last year a 32-bit count reaches
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 20;                // pipeline is 6 deep, with margin
  localparam int STUCK_LIMIT  = 2000;              // cycles with no transaction at all

  // One input transaction, at the port widths
  typedef struct packed {
    logic        mode;
    logic [31:0] count_seconds;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } cal_item_t;

  // One result transaction
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [31:0] count;
    logic        range_error;
  } cal_result_t;

  // Expected-result store plus the conversion math it is filled from
  class calendar_scoreboard;
    cal_result_t pending_results[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // Days before the first of month idx+1; idx 12 gives the year length
    function int unsigned month_start(bit leap, int unsigned idx);
      int unsigned common_tab[13];
      int unsigned leap_tab[13];
      common_tab = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
      leap_tab   = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366};
      return leap ? leap_tab[idx] : common_tab[idx];
    endfunction

    function cal_result_t calendar_of_count(logic [31:0] cnt);
      cal_result_t r;
      int unsigned days, secs, yr, mon;
      bit          leap;
      r    = '0;
      days = cnt / 86400;
      secs = cnt % 86400;
      r.second  = 6'(secs % 60);
      r.minute  = 6'((secs / 60) % 60);
      r.hour    = 5'(secs / 3600);
      r.weekday = 3'(days % 7);
      yr = EPOCH_YEAR;
      while (days >= ((yr % 4 == 0) ? 366 : 365)) begin
        days -= (yr % 4 == 0) ? 366 : 365;
        yr++;
      end
      leap = (yr % 4 == 0);
      mon  = 1;
      while (mon < 12 && days >= month_start(leap, mon)) mon++;
      r.day   = 5'(days - month_start(leap, mon - 1) + 1);
      r.month = 4'(mon);
      r.year  = 12'(yr);
      return r;
    endfunction

    function cal_result_t count_of_calendar(cal_item_t it);
      cal_result_t     r;
      int unsigned     sec, min, hr, dy, mon, yr;
      bit              leap;
      longint unsigned days, total;
      r   = '0;
      sec = 32'(it.second);
      min = 32'(it.minute);
      hr  = 32'(it.hour);
      dy  = 32'(it.day);
      mon = 32'(it.month);
      yr  = 32'(it.year);
      if (sec > 59 || min > 59 || hr > 23 || mon < 1 || mon > 12 || dy < 1 ||
          yr < EPOCH_YEAR) begin
        r.range_error = 1'b1;
        return r;
      end
      leap = (yr % 4 == 0);
      if (dy > month_start(leap, mon) - month_start(leap, mon - 1)) begin
        r.range_error = 1'b1;
        return r;
      end
      days = longint'(yr - EPOCH_YEAR) * 365 + (yr - 1) / 4 - (EPOCH_YEAR - 1) / 4
           + month_start(leap, mon - 1) + (dy - 1);
      total = ((days * 24 + hr) * 60 + min) * 60 + sec;
      if (total > 64'hFFFF_FFFF) begin
        r.count       = '1;  // saturate
        r.range_error = 1'b1;
      end else begin
        r.count = total[31:0];
      end
      return r;
    endfunction

    function cal_result_t convert(cal_item_t it);
      if (it.mode == MODE_SPLIT) return calendar_of_count(it.count_seconds);
      return count_of_calendar(it);
    endfunction

    function void note_input(cal_item_t it);
      pending_results.push_back(convert(it));
    endfunction

    function void compare_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(cal_result_t got);
      cal_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result transaction with no expected result outstanding");
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      compare_field("out_second",      exp.second,      got.second);
      compare_field("out_minute",      exp.minute,      got.minute);
      compare_field("out_hour",        exp.hour,        got.hour);
      compare_field("out_weekday",     exp.weekday,     got.weekday);
      compare_field("out_day",         exp.day,         got.day);
      compare_field("out_month",       exp.month,       got.month);
      compare_field("out_year",        exp.year,        got.year);
      compare_field("out_count",       exp.count,       got.count);
      compare_field("out_range_error", exp.range_error, got.range_error);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [31:0] in_count_seconds;
  logic [5:0]  in_second;
  logic [5:0]  in_minute;
  logic [4:0]  in_hour;
  logic [4:0]  in_day;
  logic [3:0]  in_month;
  logic [11:0] in_year;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [11:0] out_year;
  logic [31:0] out_count;
  logic        out_range_error;

  calendar_scoreboard sb = new();
  cal_item_t          stimulus_q[$];
  int                 stuck_cycles;

  seconds_calendar_converter #(.EPOCH_YEAR(EPOCH_YEAR)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_count_seconds(in_count_seconds),
    .in_second       (in_second),
    .in_minute       (in_minute),
    .in_hour         (in_hour),
    .in_day          (in_day),
    .in_month        (in_month),
    .in_year         (in_year),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_second      (out_second),
    .out_minute      (out_minute),
    .out_hour        (out_hour),
    .out_weekday     (out_weekday),
    .out_day         (out_day),
    .out_month       (out_month),
    .out_year        (out_year),
    .out_count       (out_count),
    .out_range_error (out_range_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Calendar-to-count transaction; the unused count field stays zero
  function automatic cal_item_t calendar_item(int yr, int mon, int dy, int hr, int mi, int s);
    cal_item_t it;
    it        = '0;
    it.mode   = MODE_BUILD;
    it.year   = 12'(yr);
    it.month  = 4'(mon);
    it.day    = 5'(dy);
    it.hour   = 5'(hr);
    it.minute = 6'(mi);
    it.second = 6'(s);
    return it;
  endfunction

  function automatic cal_item_t count_item(logic [31:0] cnt);
    cal_item_t it;
    it               = '0;
    it.mode          = MODE_SPLIT;
    it.count_seconds = cnt;
    return it;
  endfunction

  // Count of a known-good calendar point, used to aim mode 0 at boundaries
  function automatic logic [31:0] count_at(int yr, int mon, int dy, int hr, int mi, int s);
    cal_result_t r;
    r = sb.count_of_calendar(calendar_item(yr, mon, dy, hr, mi, s));
    return r.count;
  endfunction

  // Random transaction. Ignored fields get random bits too, so every input bit toggles.
  function automatic cal_item_t random_item();
    cal_item_t   it;
    logic [95:0] raw;
    int unsigned pick, yr, mon, mlen;
    bit          leap;
    raw  = {$urandom, $urandom, $urandom};
    it   = raw[$bits(cal_item_t)-1:0];
    pick = $urandom_range(0, 99);
    it.mode = pick[0];
    if (it.mode == MODE_SPLIT) begin
      if (pick < 60) begin
        it.count_seconds = $urandom;
      end else begin
        // just around midnight at a month or year boundary
        yr  = $urandom_range(EPOCH_YEAR, LAST_YEAR);
        mon = $urandom_range(1, 12);
        it.count_seconds = count_at(yr, mon, 1, 0, 0, 0) + $urandom_range(0, 3)
                         - $urandom_range(0, 2);
      end
    end else if (pick < 80) begin
      // well-formed date and time, mostly within the count range
      yr   = $urandom_range(EPOCH_YEAR, LAST_YEAR);
      mon  = $urandom_range(1, 12);
      leap = (yr % 4 == 0);
      mlen = sb.month_start(leap, mon) - sb.month_start(leap, mon - 1);
      it.year   = 12'(yr);
      it.month  = 4'(mon);
      it.day    = 5'($urandom_range(1, mlen));
      it.hour   = 5'($urandom_range(0, 23));
      it.minute = 6'($urandom_range(0, 59));
      it.second = 6'($urandom_range(0, 59));
    end
    // remaining mode 1 picks keep their raw bits: mostly range errors and overflows
    return it;
  endfunction

  function automatic void load_directed();
    stimulus_q.push_back(count_item(32'd0));
    stimulus_q.push_back(count_item(32'hFFFF_FFFF));
    stimulus_q.push_back(count_item(32'd86399));
    stimulus_q.push_back(count_item(32'd86400));
    stimulus_q.push_back(count_item(count_at(2017, 12, 31, 23, 59, 59)));
    stimulus_q.push_back(count_item(count_at(2020, 2, 29, 0, 0, 0)));
    stimulus_q.push_back(count_item(count_at(2020, 12, 31, 23, 59, 59)));
    stimulus_q.push_back(calendar_item(2017, 1, 1, 0, 0, 0));
    stimulus_q.push_back(calendar_item(2020, 2, 29, 23, 59, 59));
    stimulus_q.push_back(calendar_item(2017, 12, 31, 23, 59, 59));
    // top of the 32-bit range and one second past it
    stimulus_q.push_back(calendar_item(LAST_YEAR, 2, 6, 6, 28, 15));
    stimulus_q.push_back(calendar_item(LAST_YEAR, 2, 6, 6, 28, 16));
    stimulus_q.push_back(calendar_item(4095, 12, 31, 23, 59, 59));
    // day past the end of the month, Feb 29 in a common year
    stimulus_q.push_back(calendar_item(2018, 2, 29, 0, 0, 0));
    stimulus_q.push_back(calendar_item(2017, 4, 31, 12, 0, 0));
    // each field out of range on its own
    stimulus_q.push_back(calendar_item(2017, 1, 1, 0, 0, 60));
    stimulus_q.push_back(calendar_item(2017, 1, 1, 0, 0, 63));
    stimulus_q.push_back(calendar_item(2017, 1, 1, 0, 63, 0));
    stimulus_q.push_back(calendar_item(2017, 1, 1, 24, 0, 0));
    stimulus_q.push_back(calendar_item(2017, 1, 1, 31, 0, 0));
    stimulus_q.push_back(calendar_item(2017, 0, 1, 0, 0, 0));
    stimulus_q.push_back(calendar_item(2017, 13, 1, 0, 0, 0));
    stimulus_q.push_back(calendar_item(2017, 15, 1, 0, 0, 0));
    stimulus_q.push_back(calendar_item(2017, 1, 0, 0, 0, 0));
    stimulus_q.push_back(calendar_item(2016, 12, 31, 23, 59, 59));
    stimulus_q.push_back(calendar_item(0, 1, 1, 0, 0, 0));
  endfunction

  // Offer one transaction after an idle gap and hold it until accepted.
  // in_valid is only lowered when a gap follows, so it never toggles within one step.
  task automatic send_item(cal_item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= it.mode;
    in_count_seconds <= it.count_seconds;
    in_second        <= it.second;
    in_minute        <= it.minute;
    in_hour          <= it.hour;
    in_day           <= it.day;
    in_month         <= it.month;
    in_year          <= it.year;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  // Stimulus: directed list, then random; then drain and report
  initial begin
    bit no_idle;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_mode          <= MODE_SPLIT;
    in_count_seconds <= '0;
    in_second        <= '0;
    in_minute        <= '0;
    in_hour          <= '0;
    in_day           <= '0;
    in_month         <= '0;
    in_year          <= '0;
    no_idle          = 1'b0;
    load_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) stimulus_q.push_back(random_item());

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stimulus_q[i]) begin
      // occasional back-to-back stretches
      if ($urandom_range(0, 99) < 3) no_idle = !no_idle;
      send_item(stimulus_q[i], no_idle ? 0 : $urandom_range(0, 7));
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    // stray results after the last expected one are still caught here
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random stall before each transaction, with back-to-back stretches
  initial begin
    bit no_stall;
    int hold;
    out_stall <= 1'b0;
    no_stall  = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 99) < 3) no_stall = !no_stall;
      hold = no_stall ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result monitor, sampled at the edge where the transaction completes
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_second, out_minute, out_hour, out_weekday, out_day,
                        out_month, out_year, out_count, out_range_error});
    end
  end

  // Watchdog: no transaction on either channel for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
